// File: hw/rtl/upd_pkg.sv
// ----------------------------------------------------------------------------
// URL percent decoder package
// Shared types and character constants of the URL percent decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

   localparam int SLOT_DEPTH = 6;
   localparam int CNT_W      = 3;

   localparam logic [7:0] CH_PCT   = 8'h25;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_U     = 8'h75;
   localparam logic [7:0] CH_SPACE = 8'h20;

   localparam logic [CNT_W-1:0] LEN_ONE  = 3'd1;
   localparam logic [CNT_W-1:0] LEN_PCT2 = 3'd3;
   localparam logic [CNT_W-1:0] LEN_PCTU = 3'd6;

   localparam logic [15:0] CP_2B_MIN  = 16'h0080;
   localparam logic [15:0] CP_3B_MIN  = 16'h0800;
   localparam logic [15:0] CP_SUR_LO  = 16'hD800;
   localparam logic [15:0] CP_SUR_END = 16'hE000;
   localparam logic [7:0]  UTF_CONT   = 8'h80;
   localparam logic [7:0]  UTF_LEAD2  = 8'hC0;
   localparam logic [7:0]  UTF_LEAD3  = 8'hE0;
   localparam logic [7:0]  UTF_MASK6  = 8'h3F;

   typedef struct packed {
      logic [7:0] data;
      logic       is_pct;
      logic       is_plus;
      logic       is_u;
      logic       is_hex;
      logic [3:0] nib;
   } upd_sym_type;

   typedef struct packed {
      upd_sym_type sym;
      logic        eos;
   } upd_item_type;

   typedef enum logic {
      ST_LOAD,
      ST_SCAN
   } upd_state_type;

   typedef enum logic [1:0] {
      SCAN_BAD,
      SCAN_OK,
      SCAN_MORE
   } upd_scan_type;

endpackage

// File: hw/rtl/upd_front.sv
// ----------------------------------------------------------------------------
// URL percent decoder front end
// Accepts encoded bytes and tags each one with its character class.
// ----------------------------------------------------------------------------
module upd_front import upd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,
   input  logic         req_tlast,
   input  logic         q_full,
   output logic         q_push,
   output upd_item_type q_item
);

   logic seen_ff;
   logic seen_in;

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && req_tready;
   assign seen_in    = q_push ? 1'b1 : seen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else begin
         seen_ff <= seen_in;
      end
   end

   always_comb begin
      q_item             = '0;
      q_item.eos         = req_tlast;
      q_item.sym.data    = req_tdata;
      q_item.sym.is_pct  = (req_tdata == CH_PCT);
      q_item.sym.is_plus = (req_tdata == CH_PLUS);
      q_item.sym.is_u    = (req_tdata == CH_U);
      priority if (req_tdata >= 8'h30 && req_tdata <= 8'h39) begin
         q_item.sym.is_hex = 1'b1;
         q_item.sym.nib    = req_tdata[3:0];
      end else if ((req_tdata >= 8'h41 && req_tdata <= 8'h46) ||
                   (req_tdata >= 8'h61 && req_tdata <= 8'h66)) begin
         q_item.sym.is_hex = 1'b1;
         q_item.sym.nib    = req_tdata[3:0] + 4'd9;
      end else begin
         q_item.sym.is_hex = 1'b0;
      end
   end

   property p_tready_follows_queue;
      @(posedge clock) disable iff (reset) q_full |-> !q_push;
   endproperty
   property p_seen_after_push;
      @(posedge clock) disable iff (reset) q_push |=> seen_ff;
   endproperty
   property p_seen_sticks;
      @(posedge clock) disable iff (reset) seen_ff |=> seen_ff;
   endproperty

   a_tready_follows_queue: assert property (p_tready_follows_queue)
      else $error("push while queue full");
   a_seen_after_push: assert property (p_seen_after_push)
      else $error("accept flag not set");
   a_seen_sticks: assert property (p_seen_sticks)
      else $error("accept flag cleared");

endmodule

// File: hw/rtl/upd_fifo.sv
// ----------------------------------------------------------------------------
// URL percent decoder queue
// Short register queue between the front end and the decode engine.
// ----------------------------------------------------------------------------
module upd_fifo import upd_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  upd_item_type push_item,
   output logic         full,
   input  logic         pop,
   output logic         valid,
   output upd_item_type pop_item
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   upd_item_type   mem_ff [DEPTH];
   logic [PW-1:0]  wr_ff;
   logic [PW-1:0]  wr_in;
   logic [PW-1:0]  rd_ff;
   logic [PW-1:0]  rd_in;
   logic [CW-1:0]  count_ff;
   logic [CW-1:0]  count_in;

   assign full     = (count_ff == CW'(DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_item = mem_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

   property p_no_pop_empty;
      @(posedge clock) disable iff (reset) pop |-> valid;
   endproperty
   property p_count_step;
      @(posedge clock) disable iff (reset) (push && !pop) |=> count_ff == $past(count_ff) + 1'b1;
   endproperty
   property p_ptr_match;
      @(posedge clock) disable iff (reset) (count_ff == '0) |-> (wr_ff == rd_ff);
   endproperty

   a_no_pop_empty: assert property (p_no_pop_empty)
      else $error("pop from empty queue");
   a_count_step: assert property (p_count_step)
      else $error("queue count did not advance");
   a_ptr_match: assert property (p_ptr_match)
      else $error("queue pointers differ while empty");

endmodule

// File: hw/rtl/upd_back.sv
// ----------------------------------------------------------------------------
// URL percent decoder engine
// Holds undecided escape bytes, decodes them one result per cycle while the
// result channel is not stalled, and drives the registered result channel.
// ----------------------------------------------------------------------------
module upd_back import upd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         item_valid,
   input  upd_item_type item,
   output logic         item_pop,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata,
   output logic         rsp_tuser,
   output logic         rsp_tlast
);

   upd_state_type    state_ff;
   upd_state_type    state_in;
   upd_sym_type      slot_ff [SLOT_DEPTH];
   upd_sym_type      slot_in [SLOT_DEPTH];
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic             last_ff;
   logic             last_in;
   logic [1:0]       idx_ff;
   logic [1:0]       idx_in;
   logic             hold_v_ff;
   logic             hold_v_in;
   logic [7:0]       hold_ff;
   logic [7:0]       hold_in;
   logic             rsp_v_ff;
   logic             rsp_v_in;
   logic [7:0]       rsp_data_ff;
   logic [7:0]       rsp_data_in;
   logic             rsp_has_ff;
   logic             rsp_has_in;
   logic             rsp_last_ff;
   logic             rsp_last_in;

   upd_scan_type     hst;
   upd_scan_type     ust;
   logic [15:0]      code;
   logic [1:0]       nb;
   logic [7:0]       ub0;
   logic [7:0]       ub1;
   logic [7:0]       ub2;
   logic [7:0]       ub_sel;

   logic             act_emit;
   logic [7:0]       emit_val;
   logic [CNT_W-1:0] shift_amt;
   logic             step_end;
   logic [1:0]       idx_next;
   logic             is_bad;
   logic             is_partial;
   logic             out_free;
   logic             need_out;
   logic             go;

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_has_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      hst = SCAN_OK;
      for (int k = 0; k < 2; k++) begin
         if (hst == SCAN_OK) begin
            if (cnt_ff <= CNT_W'(1 + k)) begin
               hst = SCAN_MORE;
            end else if (!slot_ff[1 + k].is_hex) begin
               hst = SCAN_BAD;
            end
         end
      end
      ust = SCAN_OK;
      for (int k = 0; k < 4; k++) begin
         if (ust == SCAN_OK) begin
            if (cnt_ff <= CNT_W'(2 + k)) begin
               ust = SCAN_MORE;
            end else if (!slot_ff[2 + k].is_hex) begin
               ust = SCAN_BAD;
            end
         end
      end
   end

   assign code = {slot_ff[2].nib, slot_ff[3].nib, slot_ff[4].nib, slot_ff[5].nib};

   always_comb begin
      nb  = 2'd0;
      ub0 = '0;
      ub1 = '0;
      ub2 = '0;
      priority if (code < CP_2B_MIN) begin
         nb  = 2'd1;
         ub0 = {1'b0, code[6:0]};
      end else if (code < CP_3B_MIN) begin
         nb  = 2'd2;
         ub0 = UTF_LEAD2 | {3'b000, code[10:6]};
         ub1 = UTF_CONT | (code[7:0] & UTF_MASK6);
      end else if (code >= CP_SUR_LO && code < CP_SUR_END) begin
         nb  = 2'd0;
      end else begin
         nb  = 2'd3;
         ub0 = UTF_LEAD3 | {4'b0000, code[15:12]};
         ub1 = UTF_CONT | {2'b00, code[11:6]};
         ub2 = UTF_CONT | (code[7:0] & UTF_MASK6);
      end
      unique case (idx_ff)
         2'd0:    ub_sel = ub0;
         2'd1:    ub_sel = ub1;
         2'd2:    ub_sel = ub2;
         default: ub_sel = '0;
      endcase
   end

   always_comb begin
      act_emit   = 1'b0;
      emit_val   = '0;
      shift_amt  = '0;
      step_end   = 1'b0;
      idx_next   = idx_ff;
      is_bad     = 1'b0;
      is_partial = 1'b0;
      item_pop   = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            item_pop = item_valid;
         end
         ST_SCAN: begin
            priority if (cnt_ff == '0) begin
               step_end = 1'b1;
            end else if (slot_ff[0].is_pct) begin
               priority if (cnt_ff == LEN_ONE) begin
                  is_partial = 1'b1;
               end else if (slot_ff[1].is_u) begin
                  unique case (ust)
                     SCAN_OK: begin
                        if (nb == 2'd0) begin
                           shift_amt = LEN_PCTU;
                        end else begin
                           act_emit = 1'b1;
                           emit_val = ub_sel;
                           if (idx_ff == nb - 2'd1) begin
                              shift_amt = LEN_PCTU;
                              idx_next  = 2'd0;
                           end else begin
                              idx_next = idx_ff + 2'd1;
                           end
                        end
                     end
                     SCAN_MORE: is_partial = 1'b1;
                     default:   is_bad = 1'b1;
                  endcase
               end else begin
                  unique case (hst)
                     SCAN_OK: begin
                        act_emit  = 1'b1;
                        emit_val  = {slot_ff[1].nib, slot_ff[2].nib};
                        shift_amt = LEN_PCT2;
                     end
                     SCAN_MORE: is_partial = 1'b1;
                     default:   is_bad = 1'b1;
                  endcase
               end
               if (is_bad || (is_partial && last_ff)) begin
                  act_emit  = 1'b1;
                  emit_val  = CH_PCT;
                  shift_amt = LEN_ONE;
               end else if (is_partial) begin
                  step_end = 1'b1;
               end
            end else if (slot_ff[0].is_plus) begin
               act_emit  = 1'b1;
               emit_val  = CH_SPACE;
               shift_amt = LEN_ONE;
            end else begin
               act_emit  = 1'b1;
               emit_val  = slot_ff[0].data;
               shift_amt = LEN_ONE;
            end
         end
         default: begin
            item_pop = 1'b0;
         end
      endcase
   end

   assign out_free = !rsp_v_ff || rsp_tready;
   assign need_out = (act_emit && hold_v_ff) || (step_end && (hold_v_ff || last_ff));
   assign go       = out_free || !need_out;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (item_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (step_end && go) begin
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      slot_in     = slot_ff;
      cnt_in      = cnt_ff;
      last_in     = last_ff;
      idx_in      = idx_ff;
      hold_v_in   = hold_v_ff;
      hold_in     = hold_ff;
      rsp_v_in    = rsp_v_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_has_in  = rsp_has_ff;
      rsp_last_in = rsp_last_ff;
      if (item_pop) begin
         slot_in[cnt_ff] = item.sym;
         cnt_in          = cnt_ff + 1'b1;
         last_in         = item.eos;
      end
      if (state_ff == ST_SCAN && go) begin
         if (act_emit) begin
            if (hold_v_ff) begin
               rsp_v_in    = 1'b1;
               rsp_data_in = hold_ff;
               rsp_has_in  = 1'b1;
               rsp_last_in = 1'b0;
            end
            hold_in   = emit_val;
            hold_v_in = 1'b1;
         end
         if (step_end) begin
            if (hold_v_ff) begin
               rsp_v_in    = 1'b1;
               rsp_data_in = hold_ff;
               rsp_has_in  = 1'b1;
               rsp_last_in = last_ff;
            end else if (last_ff) begin
               rsp_v_in    = 1'b1;
               rsp_data_in = '0;
               rsp_has_in  = 1'b0;
               rsp_last_in = 1'b1;
            end
            hold_v_in = 1'b0;
         end
         unique case (shift_amt)
            LEN_ONE: begin
               for (int i = 0; i < SLOT_DEPTH - 1; i++) begin
                  slot_in[i] = slot_ff[i + 1];
               end
            end
            LEN_PCT2: begin
               for (int i = 0; i < SLOT_DEPTH - 3; i++) begin
                  slot_in[i] = slot_ff[i + 3];
               end
            end
            default: begin
               slot_in = slot_ff;
            end
         endcase
         cnt_in = cnt_ff - shift_amt;
         idx_in = idx_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_LOAD;
         cnt_ff    <= '0;
         last_ff   <= 1'b0;
         idx_ff    <= '0;
         hold_v_ff <= 1'b0;
         rsp_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         last_ff   <= last_in;
         idx_ff    <= idx_in;
         hold_v_ff <= hold_v_in;
         rsp_v_ff  <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff     <= slot_in;
      hold_ff     <= hold_in;
      rsp_data_ff <= rsp_data_in;
      rsp_has_ff  <= rsp_has_in;
      rsp_last_ff <= rsp_last_in;
   end

   property p_load_hold_empty;
      @(posedge clock) disable iff (reset) (state_ff == ST_LOAD) |-> !hold_v_ff;
   endproperty
   property p_load_room;
      @(posedge clock) disable iff (reset)
         (state_ff == ST_LOAD) |-> (cnt_ff < CNT_W'(SLOT_DEPTH));
   endproperty
   property p_pending_fits;
      @(posedge clock) disable iff (reset)
         (state_ff == ST_SCAN && step_end) |-> (cnt_ff < CNT_W'(SLOT_DEPTH));
   endproperty
   property p_utf_index;
      @(posedge clock) disable iff (reset)
         (idx_ff != 2'd0) |-> (state_ff == ST_SCAN && slot_ff[0].is_pct && slot_ff[1].is_u);
   endproperty

   a_load_hold_empty: assert property (p_load_hold_empty)
      else $error("held result left over between transactions");
   a_load_room: assert property (p_load_room)
      else $error("no room for a new byte");
   a_pending_fits: assert property (p_pending_fits)
      else $error("pending escape too long");
   a_utf_index: assert property (p_utf_index)
      else $error("stray UTF-8 byte index");

endmodule

// File: hw/rtl/url_percent_decoder.sv
// ----------------------------------------------------------------------------
// URL percent decoder
// Streaming decoder of URL-encoded text with %XX and %uXXXX escapes.
// ----------------------------------------------------------------------------
// One encoded byte enters per transaction on req_; decoded bytes leave on rsp_.
// The front end tags each byte and parks it in a short queue; the engine takes
// one byte from the queue, emits the decoded bytes that are ready one at a time
// and closes the transaction before it takes the next byte. The last byte
// of a string always yields at least one result, with rsp_tlast set on its
// final one.
module url_percent_decoder import upd_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // in_byte
   input  logic       req_tlast,   // end_of_string
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_byte
   output logic       rsp_tuser,   // has_byte
   output logic       rsp_tlast    // last_out
);

   logic         q_full;
   logic         q_push;
   upd_item_type q_item;
   logic         q_pop;
   logic         q_valid;
   upd_item_type q_head;

   upd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (q_item)
   );

   upd_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_item  (q_head)
   );

   upd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (q_valid),
      .item       (q_head),
      .item_pop   (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: tb/url_percent_decoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// URL percent decoder testbench
// Feeds encoded strings one byte per transaction, predicts the decoded byte
// stream with an independent percent and %u decoder, and compares every
// result transaction field by field under changing back-pressure and gaps.
// ----------------------------------------------------------------------------
module url_percent_decoder_tb import upd_pkg::*;;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       last_out;
   } decoded_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;   // in_byte
   logic       req_tlast;   // end_of_string
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;   // out_byte
   logic       rsp_tuser;   // has_byte
   logic       rsp_tlast;   // last_out

   decoded_type decoded_q[$];
   logic [7:0]  held_bytes[0:4];
   int          held_count;
   logic [7:0]  window[0:5];
   logic [7:0]  step_byte[0:7];
   logic        step_has[0:7];
   int          step_count;

   int sender_idle_pct;
   int receiver_stall_pct;
   int bytes_sent;
   int strings_sent;
   int results_checked;
   int failures;

   url_percent_decoder DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      if (c >= "0" && c <= "9") return {1'b1, c[3:0]};
      if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) return {1'b1, c[3:0] + 4'd9};
      return 5'b0;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] v, input bit lower);
      if (v < 10) return "0" + v;
      return (lower ? "a" : "A") + v - 8'd10;
   endfunction

   task automatic add_step_result(input logic [7:0] b, input logic has);
      step_byte[step_count] = b;
      step_has[step_count]  = has;
      step_count++;
   endtask

   task automatic scan_hex(input int from, input int n, input int ndig,
                           output upd_scan_type st, output logic [15:0] val);
      int k;
      logic [4:0] h;
      st  = SCAN_OK;
      val = '0;
      for (k = 0; k < ndig && st == SCAN_OK; k++) begin
         if (from + k >= n) begin
            st = SCAN_MORE;
         end else begin
            h = hex_digit(window[from + k]);
            if (!h[4]) st = SCAN_BAD;
            else val = {val[11:0], h[3:0]};
         end
      end
   endtask

   task automatic emit_code_point(input logic [15:0] cp);
      if (cp < CP_2B_MIN) begin
         add_step_result(cp[7:0], 1'b1);
      end else if (cp < CP_3B_MIN) begin
         add_step_result(UTF_LEAD2 | {3'b0, cp[10:6]}, 1'b1);
         add_step_result(UTF_CONT | {2'b0, cp[5:0]}, 1'b1);
      end else if (!(cp >= CP_SUR_LO && cp < CP_SUR_END)) begin
         add_step_result(UTF_LEAD3 | {4'b0, cp[15:12]}, 1'b1);
         add_step_result(UTF_CONT | {2'b0, cp[11:6]}, 1'b1);
         add_step_result(UTF_CONT | {2'b0, cp[5:0]}, 1'b1);
      end
   endtask

   task automatic predict_decode(input logic [7:0] in_byte, input logic eos);
      int n;
      int pos;
      int k;
      bit stalled;
      upd_scan_type st;
      logic [15:0] code;
      decoded_type d;
      n = held_count;
      for (k = 0; k < n; k++) window[k] = held_bytes[k];
      window[n] = in_byte;
      n++;
      pos = 0;
      stalled = 1'b0;
      step_count = 0;
      while (pos < n && !stalled) begin
         if (window[pos] == CH_PCT) begin
            if (pos + 1 >= n) begin
               st = SCAN_MORE;
            end else if (window[pos + 1] == CH_U) begin
               scan_hex(pos + 2, n, 4, st, code);
               if (st == SCAN_OK) begin
                  emit_code_point(code);
                  pos += 6;
               end
            end else begin
               scan_hex(pos + 1, n, 2, st, code);
               if (st == SCAN_OK) begin
                  add_step_result(code[7:0], 1'b1);
                  pos += 3;
               end
            end
            if (st == SCAN_MORE && !eos) begin
               stalled = 1'b1;
            end else if (st != SCAN_OK) begin
               add_step_result(CH_PCT, 1'b1);
               pos++;
            end
         end else if (window[pos] == CH_PLUS) begin
            add_step_result(CH_SPACE, 1'b1);
            pos++;
         end else begin
            add_step_result(window[pos], 1'b1);
            pos++;
         end
      end
      held_count = 0;
      if (!eos) begin
         for (k = pos; k < n && held_count < 5; k++) begin
            held_bytes[held_count] = window[k];
            held_count++;
         end
      end else if (step_count == 0) begin
         add_step_result(8'h00, 1'b0);
      end
      for (k = 0; k < step_count; k++) begin
         d.out_byte = step_byte[k];
         d.has_byte = step_has[k];
         d.last_out = eos && (k == step_count - 1);
         decoded_q.push_back(d);
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input logic eos);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eos;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_decode(b, eos);
      bytes_sent++;
      if (eos) strings_sent++;
   endtask

   task automatic send_text(input string s, input logic eos);
      int k;
      for (k = 0; k < s.len(); k++) send_byte(s[k], eos && (k == s.len() - 1));
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (decoded_q.size() != 0) @(posedge clock);
   endtask

   task automatic send_random_string(input bit pause_midway);
      logic [7:0] text[$];
      logic [15:0] cp;
      logic [7:0] b;
      int tokens;
      int kind;
      int k;
      int j;
      tokens = $urandom_range(1, 4);
      for (k = 0; k < tokens; k++) begin
         kind = $urandom_range(0, 99);
         if (kind < 22) begin
            text.push_back(8'($urandom_range(0, 255)));
         end else if (kind < 30) begin
            text.push_back(CH_PLUS);
         end else if (kind < 52) begin
            b = 8'($urandom_range(0, 255));
            text.push_back(CH_PCT);
            text.push_back(hex_char(b[7:4], 1'($urandom_range(0, 1))));
            text.push_back(hex_char(b[3:0], 1'($urandom_range(0, 1))));
         end else if (kind < 82) begin
            case ($urandom_range(0, 3))
               0: cp = 16'($urandom_range(16'h0000, 16'h007F));
               1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
               2: cp = 16'($urandom_range(16'hD800, 16'hDFFF));
               default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
            endcase
            text.push_back(CH_PCT);
            text.push_back(CH_U);
            for (j = 3; j >= 0; j--)
               text.push_back(hex_char(cp[j*4 +: 4], 1'($urandom_range(0, 1))));
         end else begin
            text.push_back(CH_PCT);
            if ($urandom_range(0, 1)) begin
               text.push_back(CH_U);
               for (j = $urandom_range(0, 3); j > 0; j--)
                  text.push_back(hex_char(4'($urandom_range(0, 15)),
                                          1'($urandom_range(0, 1))));
            end else if ($urandom_range(0, 1)) begin
               text.push_back(hex_char(4'($urandom_range(0, 15)),
                                       1'($urandom_range(0, 1))));
            end
            do b = 8'($urandom_range(0, 255)); while (hex_digit(b) != 5'b0 && b != CH_PCT);
            text.push_back(b);
         end
      end
      if ($urandom_range(0, 5) == 0) begin
         text.push_back(CH_PCT);
         if ($urandom_range(0, 1)) text.push_back(CH_U);
         for (j = $urandom_range(0, 2); j > 0; j--)
            text.push_back(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
      end
      for (k = 0; k < text.size(); k++) begin
         if (pause_midway && k == text.size() / 2) wait_drained();
         send_byte(text[k], k == text.size() - 1);
      end
   endtask

   task automatic run_strings(input int items);
      int start;
      start = bytes_sent;
      while (bytes_sent - start < items) send_random_string(1'b0);
   endtask

   task automatic test_directed_strings();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_text("+%4a", 1'b0);
      send_text("%u20AC", 1'b0);
      send_text("%U", 1'b0);
      send_text("%uDC00", 1'b1);
      send_text("%u1", 1'b1);
      send_text("%", 1'b1);
   endtask

   task automatic test_streaming_no_idle();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      run_strings(30);
   endtask

   task automatic test_sender_gaps();
      sender_idle_pct    = 52;
      receiver_stall_pct = 0;
      run_strings(15);
      send_random_string(1'b1);
      run_strings(15);
   endtask

   task automatic test_receiver_stalls();
      sender_idle_pct    = 0;
      receiver_stall_pct = 52;
      run_strings(30);
   endtask

   task automatic test_both_idle();
      sender_idle_pct    = 36;
      receiver_stall_pct = 36;
      run_strings(30);
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin : check_results
      decoded_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_checked++;
         if (decoded_q.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("%t: unexpected result byte=%h has=%b last=%b", $realtime,
                        rsp_tdata, rsp_tuser, rsp_tlast);
         end else begin
            want = decoded_q.pop_front();
            if (rsp_tdata !== want.out_byte || rsp_tuser !== want.has_byte ||
                rsp_tlast !== want.last_out) begin
               failures++;
               if (failures <= 10)
                  $display("%t: mismatch expected byte=%h has=%b last=%b, got byte=%h has=%b last=%b",
                           $realtime, want.out_byte, want.has_byte, want.last_out,
                           rsp_tdata, rsp_tuser, rsp_tlast);
            end
         end
      end
   end

   initial begin
      #2000000;
      $display("Timed out with %0d results still awaited.", decoded_q.size());
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      bytes_sent         = 0;
      strings_sent       = 0;
      results_checked    = 0;
      failures           = 0;
      held_count         = 0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= 8'h00;
      req_tlast  <= 1'b0;
      rsp_tready <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_directed_strings();
      test_streaming_no_idle();
      test_sender_gaps();
      test_receiver_stalls();
      test_both_idle();

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d encoded bytes in %0d strings and checked %0d decoded transactions",
               bytes_sent, strings_sent, results_checked);
      $display("under free-running, sender-gap, receiver-stall and mixed flow; %0d failures.",
               failures);
      if (failures == 0 && decoded_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
